FILE: hw/rtl/sm3_hash_engine_core_assert.svh
// Assertion macros shared by the SM3 engine RTL.
`ifndef SM3_HASH_ENGINE_CORE_ASSERT_SVH
`define SM3_HASH_ENGINE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SM3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sm3_pkg.sv
// Types, constants and helper functions of the SM3 engine.
package sm3_pkg;

    typedef logic [31:0]        word_t;
    typedef logic [7:0][31:0]   state8_t;
    typedef logic [15:0][31:0]  window_t;

    // Round constants
    localparam word_t T_LOW      = 32'h79CC4519;
    localparam word_t T_HIGH     = 32'h7A879D8A;

    // Padding marker byte 0x80 in the top byte of a word
    localparam word_t PAD_MARKER = 32'h8000_0000;

    // Slot 14 of 16 is bit 448: start of the length field
    localparam logic [3:0] LEN_SLOT  = 4'd14;
    localparam logic [3:0] LAST_SLOT = 4'd15;

    localparam logic [5:0] EARLY_END  = 6'd15;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    localparam logic [2:0] FULL_BYTES    = 3'd4;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    // Initial vector, word 0 in the low slot
    localparam state8_t SM3_IV = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } sm3_state_t;

    // Sequencer to compression unit
    typedef struct packed {
        logic  shift_en;
        word_t shift_word;
        logic  start;
        logic  round_en;
        logic  round_last;
        logic  t_switch;
        logic  early;
        logic  iv_load;
    } comp_ctrl_t;

    function automatic word_t rotl(input word_t x, input logic [4:0] n);
        return (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

FILE: hw/rtl/sm3_if.sv
// Valid/ready stream interfaces for message words in and digest words out.
interface sm3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic [2:0]  valid_bytes;
    logic        is_last;

    modport source (output valid, output msg_word, output valid_bytes, output is_last,
                    input ready);
    modport sink   (input valid, input msg_word, input valid_bytes, input is_last,
                    output ready);
endinterface

interface sm3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_end;

    modport source (output valid, output digest_word, output word_index, output digest_end,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input digest_end,
                    output ready);
endinterface

FILE: hw/rtl/sm3_round.sv
// One SM3 compression round: the shared datapath used 64 times per block.
module sm3_round (
    input  sm3_pkg::state8_t work_in,
    input  sm3_pkg::word_t   w_j,
    input  sm3_pkg::word_t   w_j4,
    input  sm3_pkg::word_t   t_rot,
    input  logic             early,
    output sm3_pkg::state8_t work_out
);
    import sm3_pkg::*;

    word_t a12;
    word_t ss1;
    word_t ss2;
    word_t ff;
    word_t gg;
    word_t tt1;
    word_t tt2;

    // Boolean functions switch after round 15
    always_comb
    begin
        a12 = rotl(work_in[0], 5'd12);
        ss1 = rotl(a12 + work_in[4] + t_rot, 5'd7);
        ss2 = ss1 ^ a12;
        if (early)
        begin
            ff = work_in[0] ^ work_in[1] ^ work_in[2];
            gg = work_in[4] ^ work_in[5] ^ work_in[6];
        end
        else
        begin
            ff = (work_in[0] & work_in[1]) | (work_in[0] & work_in[2])
               | (work_in[1] & work_in[2]);
            gg = (work_in[4] & work_in[5]) | (~work_in[4] & work_in[6]);
        end
        tt1 = ff + work_in[3] + ss2 + (w_j ^ w_j4);
        tt2 = gg + work_in[7] + ss1 + w_j;
    end

    // Register rotation A..H
    always_comb
    begin
        work_out[0] = tt1;
        work_out[1] = work_in[0];
        work_out[2] = rotl(work_in[1], 5'd9);
        work_out[3] = work_in[2];
        work_out[4] = perm0(tt2);
        work_out[5] = work_in[4];
        work_out[6] = rotl(work_in[5], 5'd19);
        work_out[7] = work_in[6];
    end

endmodule

FILE: hw/rtl/sm3_compress.sv
// Compression unit: block window, message expansion, working and chaining registers.
module sm3_compress (
    input  logic                clk,
    input  logic                rst_n,
    input  sm3_pkg::comp_ctrl_t ctrl,
    output sm3_pkg::state8_t    cv
);
    import sm3_pkg::*;

    window_t win_reg;
    window_t win_next;
    state8_t work_reg;
    state8_t work_next;
    state8_t cv_reg;
    state8_t cv_next;
    state8_t round_out;
    word_t   t_reg;
    word_t   t_next;
    word_t   w_new;

    sm3_round u_round (
        .work_in  (work_reg),
        .w_j      (win_reg[0]),
        .w_j4     (win_reg[4]),
        .t_rot    (t_reg),
        .early    (ctrl.early),
        .work_out (round_out)
    );

    // Next expanded word W[j+16] from the sliding window
    always_comb
    begin
        w_new = perm1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
              ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];
    end

    // Window fills from the input, then slides through the rounds
    always_comb
    begin
        win_next  = win_reg;
        work_next = work_reg;
        t_next    = t_reg;
        cv_next   = cv_reg;
        priority if (ctrl.shift_en)
            win_next = {ctrl.shift_word, win_reg[15:1]};
        else if (ctrl.round_en)
            win_next = {w_new, win_reg[15:1]};
        if (ctrl.start)
        begin
            work_next = cv_reg;
            t_next    = T_LOW;
        end
        else if (ctrl.round_en)
        begin
            work_next = round_out;
            t_next    = ctrl.t_switch ? rotl(T_HIGH, 5'd16) : rotl(t_reg, 5'd1);
        end
        // Feed-forward on the last round; IV reload after a digest
        priority if (ctrl.iv_load)
            cv_next = SM3_IV;
        else if (ctrl.round_en && ctrl.round_last)
            cv_next = cv_reg ^ round_out;
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
        t_reg    <= t_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg <= SM3_IV;
        else
            cv_reg <= cv_next;
    end

    assign cv = cv_reg;

endmodule

FILE: hw/rtl/sm3_hash_engine_core.sv
// Top level of the SM3 engine: input sequencer, padding, compression control, digest output.
//
// SM3 hash of a byte message fed as big-endian 32-bit words. Every sixteenth word
// starts a compression, one round per cycle through the single shared round unit,
// with ready low meanwhile, so no new word is taken until it is through. On the last
// word the engine writes the padding and length words one per cycle, runs one or two
// compressions (two when fewer than two free slots remain once the marker byte is
// in the block), then offers the eight digest words, index 0 first, one per cycle as
// the sink takes them; input ready returns the cycle after the eighth word is taken,
// with the chaining value back at the initial vector. No clearing pass is needed
// after reset.
`include "sm3_hash_engine_core_assert.svh"

module sm3_hash_engine_core (
    input logic       clk,
    input logic       rst_n,
    sm3_in_if.sink    msg_in,
    sm3_out_if.source digest_out
);
    import sm3_pkg::*;

    sm3_state_t  state_reg;
    sm3_state_t  state_next;
    logic [3:0]  fill_reg;
    logic [3:0]  fill_next;
    logic [63:0] bit_len_reg;
    logic [63:0] bit_len_next;
    logic [5:0]  round_reg;
    logic [5:0]  round_next;
    logic [2:0]  out_idx_reg;
    logic [2:0]  out_idx_next;
    logic        marker_reg;
    logic        marker_next;
    logic        len_phase_reg;
    logic        len_phase_next;
    logic        pad_reg;
    logic        pad_next;
    logic        final_reg;
    logic        final_next;

    logic        in_fire;
    logic        out_fire;
    logic        out_done;
    logic [2:0]  nbytes;
    word_t       padded_word;
    logic        push_en;
    word_t       push_word;
    logic        wrap;
    comp_ctrl_t  ctrl;
    state8_t     cv;

    sm3_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cv    (cv)
    );

    assign in_fire  = msg_in.valid & msg_in.ready;
    assign out_fire = digest_out.valid & digest_out.ready;
    assign out_done = out_fire && (out_idx_reg == LAST_WORD_IDX);

    // Last word: keep the valid bytes and append the marker byte if the word has room
    always_comb
    begin
        nbytes = (msg_in.valid_bytes > FULL_BYTES) ? FULL_BYTES : msg_in.valid_bytes;
        unique case (nbytes)
            3'd0:    padded_word = PAD_MARKER;
            3'd1:    padded_word = {msg_in.msg_word[31:24], PAD_MARKER[31:8]};
            3'd2:    padded_word = {msg_in.msg_word[31:16], PAD_MARKER[31:16]};
            3'd3:    padded_word = {msg_in.msg_word[31:8], PAD_MARKER[31:24]};
            default: padded_word = msg_in.msg_word;
        endcase
    end

    // Word written into the block window this cycle
    always_comb
    begin
        push_en   = 1'b0;
        push_word = msg_in.msg_word;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    push_en   = 1'b1;
                    push_word = msg_in.is_last ? padded_word : msg_in.msg_word;
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                priority if (marker_reg)
                    push_word = PAD_MARKER;
                else if (len_phase_reg)
                    push_word = bit_len_reg[31:0];
                else if (fill_reg == LEN_SLOT)
                    push_word = bit_len_reg[63:32];
                else
                    push_word = '0;
            end
            default:
            begin
                push_en = 1'b0;
            end
        endcase
        wrap = push_en && (fill_reg == LAST_SLOT);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = wrap ? ST_COMP : (msg_in.is_last ? ST_PAD : ST_IDLE);
            end
            ST_PAD:
            begin
                if (wrap)
                    state_next = ST_COMP;
            end
            ST_COMP:
            begin
                if (round_reg == LAST_ROUND)
                    state_next = final_reg ? ST_OUT : (pad_reg ? ST_PAD : ST_IDLE);
            end
            ST_OUT:
            begin
                if (out_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Counters and padding flags
    always_comb
    begin
        fill_next      = fill_reg;
        bit_len_next   = bit_len_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;
        marker_next    = marker_reg;
        len_phase_next = len_phase_reg;
        pad_next       = pad_reg;
        final_next     = final_reg;
        if (push_en)
            fill_next = fill_reg + 4'd1;
        if (wrap)
            round_next = '0;
        else if (state_reg == ST_COMP)
            round_next = round_reg + 6'd1;
        if (in_fire)
        begin
            bit_len_next = bit_len_reg
                         + (msg_in.is_last ? {58'd0, nbytes, 3'd0} : 64'd32);
            if (msg_in.is_last)
            begin
                pad_next    = 1'b1;
                marker_next = (nbytes == FULL_BYTES);
            end
        end
        if (state_reg == ST_PAD)
        begin
            priority if (marker_reg)
                marker_next = 1'b0;
            else if (len_phase_reg)
            begin
                len_phase_next = 1'b0;
                final_next     = 1'b1;
            end
            else if (fill_reg == LEN_SLOT)
                len_phase_next = 1'b1;
        end
        if (out_fire)
            out_idx_next = out_idx_reg + 3'd1;
        if (out_done)
        begin
            pad_next     = 1'b0;
            final_next   = 1'b0;
            bit_len_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bit_len_reg   <= '0;
            round_reg     <= '0;
            out_idx_reg   <= '0;
            marker_reg    <= 1'b0;
            len_phase_reg <= 1'b0;
            pad_reg       <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bit_len_reg   <= bit_len_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
            marker_reg    <= marker_next;
            len_phase_reg <= len_phase_next;
            pad_reg       <= pad_next;
            final_reg     <= final_next;
        end
    end

    // Outputs: handshakes, digest word and compression control
    always_comb
    begin
        msg_in.ready           = (state_reg == ST_IDLE);
        digest_out.valid       = (state_reg == ST_OUT);
        digest_out.digest_word = cv[out_idx_reg];
        digest_out.word_index  = out_idx_reg;
        digest_out.digest_end  = (out_idx_reg == LAST_WORD_IDX);
        ctrl.shift_en          = push_en;
        ctrl.shift_word        = push_word;
        ctrl.start             = wrap;
        ctrl.round_en          = (state_reg == ST_COMP);
        ctrl.round_last        = (round_reg == LAST_ROUND);
        ctrl.t_switch          = (round_reg == EARLY_END);
        ctrl.early             = (round_reg[5:4] == 2'b00);
        ctrl.iv_load           = out_done;
    end

    `SM3_ASSERT_NOW(a_out_block_empty, clk, rst_n, digest_out.valid, fill_reg == 4'd0, "digest offered with a partly filled block")
    `SM3_ASSERT_NEXT(a_full_block_compresses, clk, rst_n, in_fire && !msg_in.is_last && fill_reg == LAST_SLOT, state_reg == ST_COMP, "full block did not start compression")
    `SM3_ASSERT_NEXT(a_rounds_advance, clk, rst_n, state_reg == ST_COMP && round_reg != LAST_ROUND, state_reg == ST_COMP && round_reg == $past(round_reg) + 6'd1, "round counter skipped or compression cut short")
    `SM3_ASSERT_NEXT(a_digest_restart, clk, rst_n, out_done, msg_in.ready && bit_len_reg == 64'd0 && !pad_reg, "engine not back to a fresh message after digest")

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench of the SM3 hash engine: random messages in, digest words checked out.
`timescale 1ns / 100ps

module tb_top;
    import sm3_pkg::*;

    typedef struct {
        word_t      msg_word;
        logic [2:0] valid_bytes;
        logic       is_last;
    } msg_item_t;

    typedef struct {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       digest_end;
    } digest_exp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    sm3_in_if  msg_in();
    sm3_out_if digest_out();

    sm3_hash_engine_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_in     (msg_in),
        .digest_out (digest_out)
    );

    always #6 clk = ~clk;

    // Words waiting to be sent and digest words waiting to arrive
    msg_item_t   msg_q[$];
    digest_exp_t digest_q[$];

    int unsigned err_count = 0;
    int unsigned digests_done = 0;

    // Predictor state
    word_t       chain_value [8];
    word_t       blk_buf [16];
    logic [63:0] msg_bits;
    logic [3:0]  slot;

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // Left rotation; a rotation by zero leaves the word alone
    function automatic word_t rol32(input word_t x, input int unsigned n);
        int unsigned sh;
        sh = n % 32;
        if (sh == 0)
            return x;
        return (x << sh) | (x >> (32 - sh));
    endfunction

    function automatic word_t sm3_p0(input word_t x);
        return x ^ rol32(x, 9) ^ rol32(x, 17);
    endfunction

    function automatic word_t sm3_p1(input word_t x);
        return x ^ rol32(x, 15) ^ rol32(x, 23);
    endfunction

    function automatic void reset_chain();
        int k;
        for (k = 0; k < 8; k++)
            chain_value[k] = SM3_IV[k];
        msg_bits = '0;
        slot = '0;
    endfunction

    // One 64-round compression of the buffered block into the chaining value
    function automatic void sm3_compress();
        word_t w [68];
        word_t v [8];
        word_t t_j, a12, ss1, ss2, ff, gg, tt1, tt2;
        int j;
        for (j = 0; j < 16; j++)
            w[j] = blk_buf[j];
        for (j = 16; j < 68; j++)
            w[j] = sm3_p1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
        for (j = 0; j < 8; j++)
            v[j] = chain_value[j];
        for (j = 0; j < 64; j++)
        begin
            t_j = (j < 16) ? T_LOW : T_HIGH;
            a12 = rol32(v[0], 12);
            ss1 = rol32(a12 + v[4] + rol32(t_j, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16)
            begin
                ff = v[0] ^ v[1] ^ v[2];
                gg = v[4] ^ v[5] ^ v[6];
            end
            else
            begin
                ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
                gg = (v[4] & v[5]) | (~v[4] & v[6]);
            end
            tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + v[7] + ss1 + w[j];
            v[3] = v[2];
            v[2] = rol32(v[1], 9);
            v[1] = v[0];
            v[0] = tt1;
            v[7] = v[6];
            v[6] = rol32(v[5], 19);
            v[5] = v[4];
            v[4] = sm3_p0(tt2);
        end
        for (j = 0; j < 8; j++)
            chain_value[j] ^= v[j];
    endfunction

    function automatic void load_slot(input word_t x);
        blk_buf[slot] = x;
        slot = slot + 4'd1;
        if (slot == 4'd0)
            sm3_compress();
    endfunction

    // Absorb one accepted word; on the last word pad, finish and queue the digest
    function automatic void absorb_msg_word(input msg_item_t it);
        int          nb;
        word_t       keep;
        word_t       all_ones;
        digest_exp_t d;
        int          k;
        all_ones = '1;
        nb = (it.valid_bytes > FULL_BYTES || !it.is_last) ? 4 : int'(it.valid_bytes);
        if (!it.is_last)
        begin
            msg_bits += 64'd32;
            load_slot(it.msg_word);
            return;
        end
        msg_bits += 64'(8 * nb);
        if (nb == 4)
        begin
            load_slot(it.msg_word);
            load_slot(PAD_MARKER);
        end
        else
        begin
            keep = (nb == 0) ? '0 : (all_ones << (32 - 8 * nb));
            load_slot((it.msg_word & keep) | (32'h80 << (24 - 8 * nb)));
        end
        // no room left for the length: pad out this block and start another
        if (slot == LAST_SLOT)
            load_slot('0);
        while (slot < LEN_SLOT)
            load_slot('0);
        load_slot(msg_bits[63:32]);
        load_slot(msg_bits[31:0]);
        for (k = 0; k < 8; k++)
        begin
            d.digest_word = chain_value[k];
            d.word_index  = 3'(k);
            d.digest_end  = (3'(k) == LAST_WORD_IDX);
            digest_q = {digest_q, d};
        end
        reset_chain();
    endfunction

    task automatic queue_word(input word_t w, input logic [2:0] vb, input logic last);
        msg_item_t it;
        it.msg_word    = w;
        it.valid_bytes = vb;
        it.is_last     = last;
        msg_q = {msg_q, it};
    endtask

    function automatic word_t pick_word();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '1;
        if (r == 1)
            return '0;
        return $urandom;
    endfunction

    // Sender: bursts of random length separated by random gaps
    msg_item_t   cur_item;
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_in.valid       <= 1'b0;
            msg_in.msg_word    <= '0;
            msg_in.valid_bytes <= '0;
            msg_in.is_last     <= 1'b0;
            burst_left = 8;
            gap_left   = 0;
        end
        else
        begin
            if (msg_in.valid && msg_in.ready)
                absorb_msg_word(cur_item);
            if (!msg_in.valid || msg_in.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    msg_in.valid <= 1'b0;
                end
                else if (msg_q.size() != 0)
                begin
                    cur_item = msg_q.pop_front();
                    msg_in.msg_word    <= cur_item.msg_word;
                    msg_in.valid_bytes <= cur_item.valid_bytes;
                    msg_in.is_last     <= cur_item.is_last;
                    msg_in.valid       <= 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    msg_in.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once the second digest is in, to back the engine up
    int unsigned hold_left;
    logic        hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && digests_done == 2)
        begin
            hold_left <= 700;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: checks each accepted digest word and stalls on a changing pattern
    digest_exp_t exp_word;
    int unsigned stall_mode;
    int unsigned stall_phase;
    logic        sink_take;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest_out.ready <= 1'b0;
            stall_mode  = 0;
            stall_phase = 0;
        end
        else
        begin
            if (digest_out.valid && digest_out.ready)
            begin
                if (digest_q.size() == 0)
                    flag_mismatch($sformatf("digest word %h idx %0d with none expected",
                                            digest_out.digest_word, digest_out.word_index));
                else
                begin
                    exp_word = digest_q.pop_front();
                    if (digest_out.digest_word !== exp_word.digest_word)
                        flag_mismatch($sformatf("digest_word %h, expected %h (idx %0d)",
                                                digest_out.digest_word, exp_word.digest_word,
                                                exp_word.word_index));
                    if (digest_out.word_index !== exp_word.word_index)
                        flag_mismatch($sformatf("word_index %0d, expected %0d",
                                                digest_out.word_index, exp_word.word_index));
                    if (digest_out.digest_end !== exp_word.digest_end)
                        flag_mismatch($sformatf("digest_end %b, expected %b (idx %0d)",
                                                digest_out.digest_end, exp_word.digest_end,
                                                exp_word.word_index));
                    if (exp_word.digest_end)
                        digests_done++;
                end
            end
            if (stall_phase == 0)
            begin
                stall_mode  = $urandom_range(0, 2);
                stall_phase = $urandom_range(16, 96);
            end
            stall_phase--;
            case (stall_mode)
                0:       sink_take = 1'b1;
                1:       sink_take = ($urandom_range(0, 1) == 1);
                default: sink_take = ($urandom_range(0, 3) == 0);
            endcase
            digest_out.ready <= sink_take && (hold_left == 0);
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int unsigned len;
        int unsigned r;
        int unsigned drain;
        int i;

        reset_chain();
        rst_n <= 1'b0;

        // empty message, with junk in the ignored bytes
        queue_word(32'hDEAD_BEEF, 3'd0, 1'b1);
        // "abc"
        queue_word(32'h6162_6300, 3'd3, 1'b1);
        queue_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        // too many valid bytes counts as four
        queue_word(32'h0000_0000, 3'd7, 1'b1);
        queue_word(32'hFFFF_FFFF, 3'd1, 1'b1);
        queue_word(32'hA5A5_5A5A, 3'd2, 1'b1);
        // short word before the end is taken whole
        queue_word(32'h0123_4567, 3'd5, 1'b0);
        queue_word(32'h89AB_CDEF, 3'd6, 1'b1);
        // last full word near the end of a block: length spills into a second block
        for (i = 0; i < 13; i++)
            queue_word(pick_word(), 3'(i % 4), 1'b0);
        queue_word(32'hFFFF_FFFF, 3'd4, 1'b1);

        // random messages, mostly short
        while (msg_q.size() < 320)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 18);
            else if (r < 95)
                len = $urandom_range(14, 34);
            else
                len = $urandom_range(40, 70);
            for (i = 1; i < len; i++)
                queue_word(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
            if ($urandom_range(0, 9) < 7)
                queue_word(pick_word(), 3'($urandom_range(0, 4)), 1'b1);
            else
                queue_word(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (msg_q.size() != 0 || msg_in.valid)
            @(posedge clk);
        drain = 0;
        while (digest_q.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (200) @(posedge clk);
        if (digest_q.size() != 0)
            flag_mismatch($sformatf("%0d digest words never arrived", digest_q.size()));

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
